/* design/cbfa_pkg.sv */
// ----------------------------------------------------------------------------
// cbfa_pkg
// shared constants for the contiguous block fit allocator
// ----------------------------------------------------------------------------
`default_nettype none

package cbfa_pkg;

  // default geometry
  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // fixed field widths
  localparam int OP_W     = 1;
  localparam int BLK_W    = 4;
  localparam int AMT_W    = 16;
  localparam int POLICY_W = 2;
  localparam int DATA_W   = 24;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

  // fit policy codes, the unused code acts as first fit
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

endpackage

`default_nettype wire

/* design/contiguous_block_fit_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_block_fit_allocator
// load word: taken while idle, loads may follow every cycle while no allocation is in progress
// allocate word: the scan reads the size ram through its single read port, one
//   entry per cycle, then ST_WRITE registers the result once the result slot
//   is free and returns to idle, where the next word is taken
// reset: synchronous rst_n clears policy, control and the per-entry valid
//   bits, so every block reads as free size zero with no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_block_fit_allocator #(
  parameter int NUM_BLOCKS = cbfa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = cbfa_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [cbfa_pkg::POLICY_W-1:0] cfg_wr_data,
  // input words
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [cbfa_pkg::DATA_W-1:0]   in_tdata,  // block_select[3:0], amount[19:4], zeros
  input  wire logic                          in_tuser,  // operation
  // result words
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [cbfa_pkg::DATA_W-1:0]   out_tdata, // chosen_block[3:0], left_over[19:4], zeros
  output logic                               out_tuser  // placed
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int EXT_W = 64;
  localparam int BLK_W = cbfa_pkg::BLK_W;
  localparam int AMT_W = cbfa_pkg::AMT_W;

  // one-hot sequencer
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cbfa_pkg::POLICY_W-1:0] policy_r, policy_nxt;
  logic [NUM_BLOCKS-1:0]        valid_r, valid_nxt;    // entry written since reset
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;        // next entry to read
  logic                         rd_pend_r, rd_pend_nxt;
  logic                         valid_rd_r, valid_rd_nxt;
  logic [IDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic [SIZE_BITS-1:0]         amt_r, amt_nxt;        // request size
  logic                         found_r, found_nxt;
  logic [IDX_W-1:0]             pick_r, pick_nxt;
  logic [SIZE_BITS-1:0]         best_r, best_nxt;      // size of current pick
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_placed_r, out_placed_nxt;
  logic [BLK_W-1:0]             out_blk_r, out_blk_nxt;
  logic [AMT_W-1:0]             out_left_r, out_left_nxt;

  // input fields
  logic                         in_op;
  logic [BLK_W-1:0]             in_blk;
  logic [AMT_W-1:0]             in_amt;
  logic                         in_acc;
  logic [8:0]                   sel_ext;
  logic                         sel_ok;
  logic [SIZE_BITS-1:0]         in_amt_m;

  // ram ports
  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr;
  logic [SIZE_BITS-1:0]         ram_wdata;
  logic                         ram_re;
  logic [SIZE_BITS-1:0]         ram_rdata;

  // scan datapath
  logic [SIZE_BITS-1:0]         cur_size;
  logic                         fits;
  logic                         take;
  logic [SIZE_BITS-1:0]         left;
  logic [EXT_W-1:0]             left_ext;
  logic [8:0]                   pick_ext;
  logic                         out_free;

  assign in_op    = in_tuser;
  assign in_blk   = in_tdata[BLK_W-1:0];
  assign in_amt   = in_tdata[BLK_W+AMT_W-1:BLK_W];
  assign in_acc   = in_tvalid && in_tready;
  assign sel_ext  = 9'(in_blk);
  // loads beyond the last block are dropped
  assign sel_ok   = sel_ext < 9'(NUM_BLOCKS);
  // amount masked to the stored size width
  assign in_amt_m = SIZE_BITS'(in_amt);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_tready;

  // entries that were never written read as zero
  assign cur_size = valid_rd_r ? ram_rdata : '0;
  assign fits     = cur_size >= amt_r;

  // ties keep the lower index since only strict improvements replace the pick
  always_comb begin
    take = 1'b0;
    if (rd_pend_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (policy_r)
          cbfa_pkg::POLICY_BEST:  take = cur_size < best_r;
          cbfa_pkg::POLICY_WORST: take = cur_size > best_r;
          default:                take = 1'b0;
        endcase
      end
    end
  end

  assign left     = best_r - amt_r;
  assign left_ext = EXT_W'(left);
  assign pick_ext = 9'(pick_r);

  // ram access: loads write at accept, allocations write back in ST_WRITE
  assign ram_re = (state_r == ST_SCAN) && (cnt_r != CNT_W'(NUM_BLOCKS));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel_ext[IDX_W-1:0];
    ram_wdata = in_amt_m;
    if (in_acc && in_op == cbfa_pkg::OP_LOAD && sel_ok) begin
      ram_we = 1'b1;
    end else if (state_r == ST_WRITE && found_r) begin
      ram_we    = 1'b1;
      ram_waddr = pick_r;
      ram_wdata = left;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    policy_nxt     = policy_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    rd_pend_nxt    = ram_re;
    valid_rd_nxt   = valid_r[cnt_r[IDX_W-1:0]];
    rd_idx_nxt     = cnt_r[IDX_W-1:0];
    amt_nxt        = amt_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_placed_nxt = out_placed_r;
    out_blk_nxt    = out_blk_r;
    out_left_nxt   = out_left_r;

    if (cfg_wr_en) begin
      policy_nxt = cfg_wr_data;
    end

    if (ram_we) begin
      valid_nxt[ram_waddr] = 1'b1;
    end

    if (take) begin
      found_nxt = 1'b1;
      pick_nxt  = rd_idx_r;
      best_nxt  = cur_size;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_op == cbfa_pkg::OP_ALLOC) begin
          amt_nxt   = in_amt_m;
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          // last read data is judged in this cycle
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // write-back repeats harmlessly while the result slot is busy
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = found_r;
          out_blk_nxt    = found_r ? pick_ext[BLK_W-1:0] : '0;
          out_left_nxt   = found_r ? left_ext[AMT_W-1:0] : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= cbfa_pkg::POLICY_FIRST;
      valid_r     <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    valid_rd_r   <= valid_rd_nxt;
    rd_idx_r     <= rd_idx_nxt;
    amt_r        <= amt_nxt;
    pick_r       <= pick_nxt;
    best_r       <= best_nxt;
    out_placed_r <= out_placed_nxt;
    out_blk_r    <= out_blk_nxt;
    out_left_r   <= out_left_nxt;
  end

  // free size table
  cbfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_sizes (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (cnt_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_placed_r;
  assign out_tdata  = {{(cbfa_pkg::DATA_W-BLK_W-AMT_W){1'b0}}, out_left_r, out_blk_r};

  // checks

  a_noplace_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("unplaced result carries nonzero data");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_BLOCKS))
    else $error("scan counter past last block");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == ST_SCAN)
    else $error("read data pending outside scan");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken during allocation");

  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> 9'(pick_r) < 9'(NUM_BLOCKS))
    else $error("pick beyond last block");

endmodule

`default_nettype wire

/* design/cbfa_ram.sv */
// ----------------------------------------------------------------------------
// cbfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cbfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire
